@@ design/text_screen_char_writer_assert.svh @@
// Assertion macros for the text screen character writer.
`ifndef TEXT_SCREEN_CHAR_WRITER_ASSERT_SVH
`define TEXT_SCREEN_CHAR_WRITER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define TSCW_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define TSCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/tscw_pkg.sv @@
// Shared types and constants of the text screen character writer.
package tscw_pkg;

  localparam int ACTION_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 11;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - POS_W - CELL_W - 1;

  localparam logic [CELL_W-1:0] ATTR_CELL  = 16'h0700;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE    = 8'd10;

  typedef enum logic [1:0] {
    ACT_PUT  = 2'd0,
    ACT_BACK = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CUR_BACK,
    CUR_NEWLINE,
    CUR_ADVANCE
  } cur_op_e;

  typedef struct packed {
    logic    upd;
    cur_op_e op;
  } cur_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK
  } state_e;

endpackage

@@ design/tscw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tscw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/tscw_cursor.sv @@
// Cursor tracker: row, column and linear cell index with wrap detection.
module tscw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tscw_pkg::cur_cmd_t                  cmd_i,
  output logic [$clog2(COLUMNS*ROWS+1)-1:0]   lin_o,
  output logic                                wrap_o
);

  import tscw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);

  logic [RW-1:0] row_q, row_d, row_n;
  logic [CW-1:0] col_q, col_d, col_n;
  logic [LW-1:0] lin_q, lin_d, lin_n;

  // Candidate position for the presented operation, before any scroll.
  always_comb begin
    row_n = row_q;
    col_n = col_q;
    lin_n = lin_q;
    unique case (cmd_i.op)
      CUR_BACK: begin
        if (lin_q != '0) begin
          lin_n = LW'(lin_q - 1'b1);
          if (col_q == '0) begin
            row_n = RW'(row_q - 1'b1);
            col_n = CW'(COLUMNS - 1);
          end else begin
            col_n = CW'(col_q - 1'b1);
          end
        end
      end
      CUR_NEWLINE: begin
        row_n = RW'(row_q + 1'b1);
        col_n = '0;
        lin_n = LW'(lin_q + LW'(COLUMNS) - LW'(col_q));
      end
      CUR_ADVANCE: begin
        lin_n = LW'(lin_q + 1'b1);
        if (col_q == CW'(COLUMNS - 1)) begin
          row_n = RW'(row_q + 1'b1);
          col_n = '0;
        end else begin
          col_n = CW'(col_q + 1'b1);
        end
      end
      default: begin
        row_n = row_q;
      end
    endcase
  end

  assign wrap_o = (row_n == RW'(ROWS));

  // Land on the start of the last row when the move runs off the screen.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    lin_d = lin_q;
    if (cmd_i.upd) begin
      if (wrap_o) begin
        row_d = RW'(ROWS - 1);
        col_d = '0;
        lin_d = LW'(CELLS - COLUMNS);
      end else begin
        row_d = row_n;
        col_d = col_n;
        lin_d = lin_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      lin_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      lin_q <= lin_d;
    end
  end

  assign lin_o = lin_q;

endmodule

@@ design/text_screen_char_writer.sv @@
// Text-mode screen writer: a COLUMNS x ROWS grid of 16-bit cells (attribute in
// the high byte, character in the low byte) held in one synchronous RAM, plus a
// cursor. An input item carries an action in tuser (put, backspace, read, or a
// no-op code) and a character byte and read address in tdata; every item gives
// exactly one result item with the cursor index, the read data and a scroll flag.
// After reset the block sweeps the RAM to zero, one cell per cycle, and accepts
// no item until the sweep is done. A put, backspace or read then makes a RAM
// access on accept and a second step for the blank write at the new cursor or
// the registered read data. The no-op code finishes in the accept cycle. A put
// or newline that runs off the bottom row adds a scroll: every cell is streamed
// through the single RAM write port, copied up one row or, on the last row,
// cleared. The result waits in an output register; the next item is taken only
// once that register is empty or is being drained in the same cycle, so a
// stalled receiver holds off the input.
`include "text_screen_char_writer_assert.svh"

module text_screen_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] char_code, [18:8] read_addr, [23:19] zero
  input  logic [tscw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] action
  input  logic [tscw_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [10:0] cursor_pos, [26:11] read_data, [27] scrolled, [31:28] zero
  output logic [tscw_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  import tscw_pkg::*;

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int LW       = $clog2(CELLS + 1);
  localparam int COPY_END = CELLS - COLUMNS;

  // Input item fields.
  act_e              in_act;
  logic [CHAR_W-1:0] in_char;
  logic [ADDR_W-1:0] in_addr;
  logic              in_fire;

  assign in_act  = act_e'(s_axis_tuser[ACTION_W-1:0]);
  assign in_char = s_axis_tdata[CHAR_W-1:0];
  assign in_addr = s_axis_tdata[CHAR_W +: ADDR_W];

  // Sequencer state.
  state_e        state_q, state_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          scr_q, scr_d;
  logic          oor_q, oor_d;

  // Cursor unit.
  cur_cmd_t      cur_cmd;
  logic [LW-1:0] cur_lin;
  logic          cur_wrap;

  // RAM port.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Scroll sweep addresses: read one row below, write one cell behind.
  logic [LW-1:0] scroll_src;
  logic [LW-1:0] scroll_dst;

  assign scroll_src = LW'(cnt_q + LW'(COLUMNS));
  assign scroll_dst = LW'(cnt_q - 1'b1);

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  out_cursor_q;
  logic [CELL_W-1:0] out_data_q, out_data_d;
  logic              out_scr_q, out_scr_d;
  logic              out_load;

  // Take an item only when the result slot is free or being drained now.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  tscw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .lin_o  (cur_lin),
    .wrap_o (cur_wrap)
  );

  tscw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_PUT:  state_d = cur_wrap ? ST_SCROLL : ST_BLANK;
            ACT_BACK: state_d = ST_BLANK;
            ACT_READ: state_d = ST_READ;
            ACT_NOP:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        if (cnt_q == LW'(CELLS)) begin
          state_d = ST_BLANK;
        end
      end
      ST_BLANK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath controls.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = '0;
    mem_raddr   = scroll_src[AW-1:0];
    cur_cmd.upd = 1'b0;
    cur_cmd.op  = CUR_ADVANCE;
    cnt_d       = cnt_q;
    scr_d       = scr_q;
    oor_d       = oor_q;
    out_load    = 1'b0;
    out_data_d  = '0;
    out_scr_d   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        // Zero one cell per cycle after reset.
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        cnt_d     = (cnt_q == LW'(CELLS - 1)) ? '0 : LW'(cnt_q + 1'b1);
      end
      ST_IDLE: begin
        mem_raddr = AW'(in_addr);
        if (in_fire) begin
          unique case (in_act)
            ACT_PUT: begin
              cur_cmd.upd = 1'b1;
              if (in_char == NEWLINE) begin
                cur_cmd.op = CUR_NEWLINE;
              end else begin
                // Store the character at the old cursor, then advance.
                cur_cmd.op = CUR_ADVANCE;
                mem_we     = 1'b1;
                mem_waddr  = cur_lin[AW-1:0];
                mem_wdata  = ATTR_CELL | {{(CELL_W - CHAR_W){1'b0}}, in_char};
              end
              scr_d = cur_wrap;
              cnt_d = '0;
            end
            ACT_BACK: begin
              cur_cmd.upd = 1'b1;
              cur_cmd.op  = CUR_BACK;
              scr_d       = 1'b0;
            end
            ACT_READ: begin
              oor_d = (int'(in_addr) >= CELLS);
            end
            ACT_NOP: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load   = 1'b1;
        out_data_d = oor_q ? '0 : mem_rdata;
      end
      ST_SCROLL: begin
        // Read row below at cnt, write the cell above it in the next cycle;
        // the last row has no source and is cleared instead.
        mem_raddr = scroll_src[AW-1:0];
        mem_we    = (cnt_q != '0);
        mem_waddr = scroll_dst[AW-1:0];
        mem_wdata = (cnt_q <= LW'(COPY_END)) ? mem_rdata : '0;
        cnt_d     = (cnt_q == LW'(CELLS)) ? '0 : LW'(cnt_q + 1'b1);
      end
      ST_BLANK: begin
        // Drop a blank at the new cursor and hand out the result.
        mem_we    = 1'b1;
        mem_waddr = cur_lin[AW-1:0];
        mem_wdata = BLANK_CELL;
        out_load  = 1'b1;
        out_scr_d = scr_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      scr_q       <= 1'b0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scr_q       <= scr_d;
      oor_q       <= oor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload holds until the next load.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cursor_q <= POS_W'(cur_lin);
      out_data_q   <= out_data_d;
      out_scr_q    <= out_scr_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_scr_q, out_data_q, out_cursor_q};

  // The result slot is always empty when an item finishes.
  `TSCW_ASSERT_IMPLY(a_slot_free, clk_i, rst_ni, (state_q == ST_READ) || (state_q == ST_BLANK), !out_valid_q, "result slot busy when an item finishes")
  // The cursor never leaves the screen.
  `TSCW_ASSERT_ALWAYS(a_cursor_range, clk_i, rst_ni, cur_lin < LW'(CELLS), "cursor beyond last cell")
  // A scroll always leaves the cursor at the start of the last row.
  `TSCW_ASSERT_IMPLY(a_scroll_cursor, clk_i, rst_ni, state_q == ST_SCROLL, cur_lin == LW'(COPY_END), "cursor not on last row during scroll")

endmodule
